[hw/rtl/rtsc_pkg.sv]
// Shared constants for the rational tanh soft clipper.
// Used by rtsc_div, the top level and the testbench; depends on nothing.
`default_nettype none
package rtsc_pkg;
   localparam int IntFrac = 24;
   localparam int MagBits = 27;             // Q3.24 magnitude, below 8.0
   localparam int RegBits = 24;
   localparam logic [26:0] VMax = 27'h7FFFFFF;
   localparam logic [25:0] KA  = 26'd41196580;
   localparam logic [25:0] KB  = 26'd14985910;
   localparam logic [25:0] KC  = 26'd13777897;
   localparam logic [25:0] KA2 = 26'd41021406;
   localparam logic [25:0] KE  = 26'd13667437;
   localparam int NumBits = 60;             // numerator width, Q.48 below 4096
   localparam int DenBits = 37;             // denominator width, Q.24 below 8192
   localparam int QuoBits = 32;             // quotient width
   localparam logic CsrDrive = 1'b0;
   localparam logic CsrInverse = 1'b1;
endpackage
`default_nettype wire

[hw/rtl/rtsc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rtsc_pkg; carries a payload tag and valid bit beside the data.
`default_nettype none
module rtsc_div #(
   parameter int TAG_BITS = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire logic [rtsc_pkg::NumBits-1:0]    in_num,
   input  wire logic [rtsc_pkg::DenBits-1:0]    in_den,
   input  wire logic [TAG_BITS-1:0]             in_tag,
   output logic                                 out_valid,
   output logic [rtsc_pkg::QuoBits-1:0]         out_quo,
   output logic [TAG_BITS-1:0]                  out_tag
);
   localparam int N = rtsc_pkg::NumBits;
   localparam int D = rtsc_pkg::DenBits;
   localparam int Q = rtsc_pkg::QuoBits;
   // The quotient is known to fit in Q bits, so only the low Q bits are resolved.
   logic [Q:0]         vld_ff;
   logic [D:0]         rem_ff [Q+1];
   logic [N-1:0]       num_ff [Q+1];
   logic [D-1:0]       den_ff [Q+1];
   logic [Q-1:0]       quo_ff [Q+1];
   logic [TAG_BITS-1:0] tag_ff [Q+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Q-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // High bits of the numerator give the starting remainder (below den).
         rem_ff[0] <= (D+1)'(in_num[N-1:Q]);
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar s = 0; s < Q; s++) begin : g_stage
      logic [D+1:0] trial;
      logic [D+1:0] diff;
      always_comb begin
         trial = {rem_ff[s], num_ff[s][Q-1-s]};
         diff  = trial - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!diff[D+1]) begin
               rem_ff[s+1] <= diff[D:0];
               quo_ff[s+1] <= {quo_ff[s][Q-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial[D:0];
               quo_ff[s+1] <= {quo_ff[s][Q-2:0], 1'b0};
            end
            num_ff[s+1] <= num_ff[s];
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[Q];
   assign out_quo   = quo_ff[Q];
   assign out_tag   = tag_ff[Q];
endmodule
`default_nettype wire

[hw/rtl/rational_tanh_soft_clipper.sv]
// Top level of the rational tanh soft clipper with drive and makeup gain.
// Depends on rtsc_pkg and rtsc_div.
// One request is taken every cycle unless the output stalls. A request passes
// through the eight front stages of drive product and shaper polynomials, the
// 33 registers of the quotient pipeline and the two output stages. The whole
// pipeline moves together and holds when a finished result waits at the
// output with rsp_ready low; req_ready is then low too.
`default_nettype none
module rational_tanh_soft_clipper #(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                               rsp_saturated,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [rtsc_pkg::RegBits-1:0]  csr_data
);
   localparam int F = SAMPLE_BITS - 1;
   localparam int R = rtsc_pkg::RegBits;
   localparam int M = rtsc_pkg::MagBits;
   localparam int PB = SAMPLE_BITS + R;       // drive product width
   localparam int Tot = F + GAIN_FRAC_BITS;
   localparam int OSh = rtsc_pkg::IntFrac + GAIN_FRAC_BITS - F;
   localparam int WB = 64;

   logic [R-1:0] drive_ff, inv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= R'(64'd1 << GAIN_FRAC_BITS);
         inv_ff   <= R'(64'd1 << GAIN_FRAC_BITS);
      end else if (csr_write) begin
         unique case (csr_index)
            rtsc_pkg::CsrDrive:   drive_ff <= csr_data;
            rtsc_pkg::CsrInverse: inv_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Front stages: S1 magnitude, S2 drive product, S3 scale and clip.
   logic [7:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[6:0], req_valid};
   end

   logic [SAMPLE_BITS-1:0] mag1_ff;  logic neg_ff [8];
   logic [PB-1:0] prod2_ff;
   logic [M-1:0]  m_ff [2:5];
   logic          sat_ff [2:7];
   logic [WB-1:0] sq4_ff, lin4_ff, am4_ff, em4_ff;
   logic [WB-1:0] quad6_ff, w6_ff;
   logic [WB-1:0] poly7_ff, w7_ff, ap7_ff, sq6_ff, am6_ff;
   logic [WB-1:0] num8_ff, dp8_ff, num9_ff, den9_ff;
   logic [WB-1:0] pv, vshift;
   logic [WB-1:0] em_w;

   always_comb begin
      pv = WB'(prod2_ff);
      if (Tot >= rtsc_pkg::IntFrac) vshift = pv >> (Tot - rtsc_pkg::IntFrac);
      else vshift = pv << (rtsc_pkg::IntFrac - Tot);
      em_w = WB'(m_ff[3]) * em4_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff[0]  <= req_sample_in[F];
         mag1_ff    <= req_sample_in[F] ? SAMPLE_BITS'(-req_sample_in) : req_sample_in;
         neg_ff[1]  <= neg_ff[0];
         prod2_ff   <= PB'(mag1_ff) * PB'(drive_ff);
         neg_ff[2]  <= neg_ff[1];
         sat_ff[2]  <= vshift > WB'(rtsc_pkg::VMax);
         m_ff[2]    <= (vshift > WB'(rtsc_pkg::VMax)) ? rtsc_pkg::VMax : vshift[M-1:0];
         // Products of the shaper, each registered.
         sq4_ff  <= (WB'(m_ff[2]) * WB'(m_ff[2])) >> rtsc_pkg::IntFrac;
         lin4_ff <= (WB'(rtsc_pkg::KC) * WB'(m_ff[2])) >> rtsc_pkg::IntFrac;
         am4_ff  <= (WB'(rtsc_pkg::KA) * WB'(m_ff[2])) >> rtsc_pkg::IntFrac;
         em4_ff  <= (WB'(rtsc_pkg::KE) * WB'(m_ff[2])) >> rtsc_pkg::IntFrac;
         quad6_ff <= ((WB'(rtsc_pkg::KB) + lin4_ff) * sq4_ff) >> rtsc_pkg::IntFrac;
         w6_ff    <= WB'(m_ff[3]) + (em_w >> rtsc_pkg::IntFrac);
         sq6_ff   <= sq4_ff;
         am6_ff   <= am4_ff;
         poly7_ff <= WB'(rtsc_pkg::KA) + am6_ff + quad6_ff;
         w7_ff    <= w6_ff;
         ap7_ff   <= WB'(rtsc_pkg::KA2) + sq6_ff;
         num8_ff  <= WB'(m_ff[5]) * poly7_ff;
         dp8_ff   <= (ap7_ff * w7_ff) >> rtsc_pkg::IntFrac;
         num9_ff  <= num8_ff;
         den9_ff  <= WB'(rtsc_pkg::KA2) + dp8_ff;
         for (int i = 3; i < 8; i++) begin
            neg_ff[i] <= neg_ff[i-1];
            sat_ff[i] <= sat_ff[i-1];
         end
         for (int i = 3; i < 6; i++) begin
            m_ff[i] <= m_ff[i-1];
         end
      end
   end

   logic dv;  logic [rtsc_pkg::QuoBits-1:0] quo;  logic [1:0] dtag;
   rtsc_div #(.TAG_BITS(2)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(vld_ff[7]),
      .in_num(num9_ff[rtsc_pkg::NumBits-1:0]),
      .in_den(den9_ff[rtsc_pkg::DenBits-1:0]),
      .in_tag({neg_ff[7], sat_ff[7]}),
      .out_valid(dv), .out_quo(quo), .out_tag(dtag)
   );

   // Output: makeup gain product, then clip and sign.
   logic          ov_ff, on_ff, os_ff;
   logic [WB-1:0] sc_ff, lim;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (advance) ov_ff <= dv;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         sc_ff <= (WB'(quo) * WB'(inv_ff)) >> OSh;
         on_ff <= dtag[1];
         os_ff <= dtag[0];
      end
   end
   assign lim = on_ff ? (WB'(1) << F) : ((WB'(1) << F) - WB'(1));

   logic                   rv_ff, rs_ff;
   logic [SAMPLE_BITS-1:0] ro_ff;
   logic [SAMPLE_BITS-1:0] mo;
   always_comb begin
      mo = (sc_ff > lim) ? lim[SAMPLE_BITS-1:0] : sc_ff[SAMPLE_BITS-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (advance) rv_ff <= ov_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ro_ff <= on_ff ? SAMPLE_BITS'(-mo) : mo;
         rs_ff <= os_ff | (sc_ff > lim);
      end
   end
   assign rsp_valid      = rv_ff;
   assign rsp_sample_out = ro_ff;
   assign rsp_saturated  = rs_ff;
endmodule
`default_nettype wire

[hw/rtl/rtsc_checker.sv]
// Port-level checker for the soft clipper, with its bind statement.
// Depends only on the top level's ports.
`default_nettype none
module rtsc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_saturated
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("request taken while stalled");
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("response right after reset");
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("idle block refuses requests");
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_saturated)) else $error("unknown saturation flag");
endmodule
bind rational_tanh_soft_clipper rtsc_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_saturated(rsp_saturated)
);
`default_nettype wire

[verif/tb_rational_tanh_soft_clipper.sv]
// Testbench for the rational tanh soft clipper: random and directed samples
// under several gain settings, checked against a bit-exact predictor.
// Depends on rtsc_pkg and the rational_tanh_soft_clipper RTL.
`default_nettype none

class clip_scoreboard;
   bit [23:0] drive;
   bit [23:0] inverse;
   bit [24:0] pending_q[$];
   int errors;
   int shown;

   function new();
      drive = 24'd65536;
      inverse = 24'd65536;
      errors = 0;
      shown = 0;
   endfunction

   // Magnitude of the shaper output in Q.24 for a Q3.24 magnitude.
   function bit [63:0] shape(bit [63:0] m);
      bit [63:0] sq, lin, quad, poly, num, em, w, den;
      sq = (m * m) >> 24;
      lin = (64'(rtsc_pkg::KC) * m) >> 24;
      quad = ((64'(rtsc_pkg::KB) + lin) * sq) >> 24;
      poly = 64'(rtsc_pkg::KA) + ((64'(rtsc_pkg::KA) * m) >> 24) + quad;
      num = m * poly;
      em = (64'(rtsc_pkg::KE) * m) >> 24;
      w = m + ((m * em) >> 24);
      den = 64'(rtsc_pkg::KA2) + (((64'(rtsc_pkg::KA2) + sq) * w) >> 24);
      return num / den;
   endfunction

   function void note_request(bit [23:0] sample);
      bit neg, sat;
      bit [63:0] mag, v, y, scaled, lim;
      bit [23:0] res;
      bit [23:0] flipped;
      neg = sample[23];
      flipped = (~sample) + 24'd1;
      mag = neg ? 64'(flipped) : 64'(sample);
      sat = 0;
      // Q1.23 times Q8.16 is Q.39; shift down to Q.24.
      v = (mag * drive) >> 15;
      if (v > 64'(rtsc_pkg::VMax)) begin
         v = 64'(rtsc_pkg::VMax);
         sat = 1;
      end
      y = shape(v);
      scaled = (y * inverse) >> 17;
      lim = neg ? 64'h800000 : 64'h7FFFFF;
      if (scaled > lim) begin
         scaled = lim;
         sat = 1;
      end
      res = neg ? (~scaled[23:0]) + 24'd1 : scaled[23:0];
      pending_q.push_back({sat, res});
   endfunction

   function void check_result(bit [23:0] sample, bit sat);
      bit [24:0] want;
      if (pending_q.size() == 0) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("unexpected response %h sat %b", sample, sat);
         end
         return;
      end
      want = pending_q.pop_front();
      if (want != {sat, sample}) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: expected %h sat %b, got %h sat %b",
                     want[23:0], want[24], sample, sat);
         end
      end
   endfunction
endclass

module tb_rational_tanh_soft_clipper;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [23:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [23:0] rsp_sample_out;
   logic rsp_saturated;
   logic csr_write = 0;
   logic csr_index = rtsc_pkg::CsrDrive;
   logic [rtsc_pkg::RegBits-1:0] csr_data = '0;

   clip_scoreboard board = new();
   int idle_cycles = 0;
   bit long_hold = 0;
   bit hold_done = 0;
   int stall_mode = 0;

   rational_tanh_soft_clipper DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out), .rsp_saturated(rsp_saturated),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Outputs are sampled at the edge; expectations are noted on accepted requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_sample_in);
         if (rsp_valid && rsp_ready) board.check_result(rsp_sample_out, rsp_saturated);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("rational_tanh_soft_clipper verification failed");
            $finish;
         end
      end
   end

   // Receiver: changes its stall pattern now and then, and holds off once at length.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (long_hold && !hold_done) begin
            rsp_ready <= 0;
            for (n = 0; n < 400; n++) @(posedge clock);
            hold_done = 1;
         end
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
         @(posedge clock);
      end
   end

   task automatic send_sample(input logic [23:0] s);
      req_valid <= 1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      int n;
      pause_sender();
      while (board.pending_q.size() != 0) @(posedge clock);
      for (n = 0; n < 60; n++) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [23:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      if (idx == rtsc_pkg::CsrDrive) board.drive = value;
      else board.inverse = value;
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 24'(24'h800000 + $urandom_range(0, 3));
         1: return 24'(24'h7FFFFF - $urandom_range(0, 3));
         2: return 24'($urandom_range(0, 16) - 8);
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic random_burst(input int count);
      int sent;
      int n;
      sent = 0;
      while (sent < count) begin
         for (n = $urandom_range(1, 30); n > 0 && sent < count; n--) begin
            send_sample(random_sample());
            sent++;
         end
         if ($urandom_range(0, 2) == 0) begin
            pause_sender();
            for (n = $urandom_range(0, 8); n > 0; n--) @(posedge clock);
         end
      end
   endtask

   task automatic directed_set();
      logic [23:0] list[$] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
                               24'h800000, 24'h800001, 24'h400000, 24'hC00000,
                               24'h555555, 24'hAAAAAA, 24'h100000, 24'hF00000};
      foreach (list[i]) send_sample(list[i]);
   endtask

   initial begin
      int n;
      logic [23:0] drives[6];
      logic [23:0] inverses[6];
      drives = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd32768, 24'd262144, 24'd0};
      inverses = '{24'd65536, 24'hFFFFFF, 24'd1, 24'd131072, 24'd16384, 24'd65536};
      for (n = 0; n < 8; n++) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_set();
      drain();
      for (int k = 0; k < 6; k++) begin
         write_reg(rtsc_pkg::CsrDrive, drives[k]);
         write_reg(rtsc_pkg::CsrInverse, inverses[k]);
         if (k == 5) begin
            directed_set();
            drain();
            write_reg(rtsc_pkg::CsrInverse, 24'd0);
            write_reg(rtsc_pkg::CsrDrive, 24'd65536);
         end
         directed_set();
         if (k == 1) begin
            long_hold = 1;
            random_burst(150);
         end
         random_burst(250);
         drain();
         // Random gain pair, not necessarily reciprocal.
         write_reg(rtsc_pkg::CsrDrive, 24'($urandom()));
         write_reg(rtsc_pkg::CsrInverse, 24'($urandom()));
         random_burst(40);
         drain();
      end
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("rational_tanh_soft_clipper verification clean");
      else
         $display("rational_tanh_soft_clipper verification failed");
      $finish;
   end
endmodule

`default_nettype wire
